### design/stack_bytecode_execute_assert.svh
// Assertion macros for the stack bytecode execution block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef STACK_BYTECODE_EXECUTE_ASSERT_SVH
`define STACK_BYTECODE_EXECUTE_ASSERT_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define SBE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbe check failed");

// Checks that cons holds in the cycle after ante holds.
`define SBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbe check failed");

`endif

### design/sbe_pkg.sv
// Shared types and constants for the stack bytecode execution block.
// No dependencies; imported by every module of the block.
package sbe_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LOCAL_COUNT = 16;
  localparam int WORD_W      = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int LOC_AW      = $clog2(LOCAL_COUNT);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] OP_ICONST_M1 = 8'd2;
  localparam logic [7:0] OP_ICONST_5  = 8'd8;
  localparam logic [7:0] OP_ILOAD_0   = 8'd26;
  localparam logic [7:0] OP_ILOAD_3   = 8'd29;
  localparam logic [7:0] OP_ISTORE_0  = 8'd59;
  localparam logic [7:0] OP_ISTORE_3  = 8'd62;
  localparam logic [7:0] OP_IMUL      = 8'd104;
  localparam logic [7:0] OP_IINC      = 8'd132;
  localparam logic [7:0] OP_IFNE      = 8'd154;
  localparam logic [7:0] OP_IF_ICMPGT = 8'd163;
  localparam logic [7:0] OP_GOTO      = 8'd167;
  localparam logic [7:0] OP_IRETURN   = 8'd172;
  localparam logic [7:0] OP_RETURN    = 8'd177;
  localparam logic [7:0] ICONST_BIAS  = 8'd3;

  typedef enum logic [2:0] {
    ST_CONTINUE    = 3'd0,
    ST_INT_RETURN  = 3'd1,
    ST_VOID_RETURN = 3'd2,
    ST_UNHANDLED   = 3'd3,
    ST_STACK_FAULT = 3'd4,
    ST_LOCAL_FAULT = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    CLS_ICONST,
    CLS_ILOAD,
    CLS_ISTORE,
    CLS_IMUL,
    CLS_IINC,
    CLS_IFNE,
    CLS_ICMPGT,
    CLS_GOTO,
    CLS_IRETURN,
    CLS_RETURN,
    CLS_UNHANDLED
  } op_class_e;

  typedef struct packed {
    logic [15:0]       pc_offset;
    status_e           status;
    logic [WORD_W-1:0] return_value;
  } result_t;

endpackage

### design/sbe_result_fifo.sv
// Result queue between the execute stage and the output channel.
// Depends on sbe_pkg for the result word type and the queue depth.
module sbe_result_fifo
  import sbe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  result_t            push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output result_t            pop_data_o,
  output logic [FIFO_CW-1:0] count_o
);

  result_t              buf_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]   count_q, count_d;
  logic                 pop;

  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = buf_q[rd_ptr_q];
  assign count_o     = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + FIFO_CW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### design/stack_bytecode_execute.sv
// Stack bytecode execution block: one opcode word in, one result word out.
// An accepted word passes the execute stage register and the result queue before it reaches the output.
// Throughput is one word per cycle while the result queue has room; the stack and local memories have a registered
// read, so a bypass of last cycle's write keeps back-to-back words exact.
// Reset empties the stack pointer, marks every local as zero and drops queued words.
// Depends on sbe_pkg, sbe_result_fifo and stack_bytecode_execute_assert.svh.
`include "stack_bytecode_execute_assert.svh"

module stack_bytecode_execute
  import sbe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         cmd_i,
  input  logic [7:0]         operand_hi_i,
  input  logic [7:0]         operand_lo_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] pc_offset_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] return_value_o
);

  // Decode stage
  logic              accept;
  op_class_e         cls_d;
  status_e           status_d;
  logic [SP_W-1:0]   sp_q, sp_d;
  logic              stk_we_d, loc_we_d;
  logic [STK_AW-1:0] stk_waddr_d, rd_a_d, rd_b_d;
  logic [LOC_AW-1:0] loc_ridx_d, loc_widx_d;
  logic              can_push, can_pop1, can_pop2;
  logic [7:0]        iconst_raw, iload_raw, istore_raw;

  // Execute stage
  logic              s1_valid_q;
  op_class_e         s1_cls_q;
  status_e           s1_status_q;
  logic              s1_stk_we_q, s1_loc_we_q;
  logic [STK_AW-1:0] s1_stk_waddr_q, s1_rd_a_q, s1_rd_b_q;
  logic [LOC_AW-1:0] s1_loc_ridx_q, s1_loc_widx_q;
  logic [15:0]       s1_branch_q;
  logic [7:0]        s1_lo_q;
  logic [3:0]        s1_const_q;

  // Memories and bypass registers
  logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
  logic [WORD_W-1:0] loc_mem [LOCAL_COUNT];
  logic [LOCAL_COUNT-1:0] loc_written_q;
  logic [WORD_W-1:0] stk_rd_a_q, stk_rd_b_q, loc_rd_q;
  logic              loc_rd_written_q;
  logic              byp_stk_we_q, byp_loc_we_q;
  logic [STK_AW-1:0] byp_stk_addr_q;
  logic [LOC_AW-1:0] byp_loc_addr_q;
  logic [WORD_W-1:0] byp_stk_data_q, byp_loc_data_q;

  logic              stk_we, loc_we;
  logic [WORD_W-1:0] tos, nos, loc_val, mul_res, stk_wdata, loc_wdata;
  logic              taken;
  result_t           res;
  result_t           fifo_out;
  logic [FIFO_CW-1:0] fifo_count;
  logic [FIFO_CW:0]  occupancy;

  // Every accepted word holds a queue slot until it leaves, so the queue never overflows.
  assign occupancy  = {1'b0, fifo_count} + (FIFO_CW + 1)'(s1_valid_q);
  assign in_ready_o = occupancy < (FIFO_CW + 1)'(FIFO_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  assign can_push   = sp_q < SP_W'(STACK_DEPTH);
  assign can_pop1   = sp_q >= SP_W'(1);
  assign can_pop2   = sp_q >= SP_W'(2);
  assign iconst_raw = cmd_i - ICONST_BIAS;
  assign iload_raw  = cmd_i - OP_ILOAD_0;
  assign istore_raw = cmd_i - OP_ISTORE_0;
  assign rd_a_d     = STK_AW'(sp_q - SP_W'(1));
  assign rd_b_d     = STK_AW'(sp_q - SP_W'(2));

  always_comb begin
    unique case (cmd_i) inside
      [OP_ICONST_M1:OP_ICONST_5]: cls_d = CLS_ICONST;
      [OP_ILOAD_0:OP_ILOAD_3]:    cls_d = CLS_ILOAD;
      [OP_ISTORE_0:OP_ISTORE_3]:  cls_d = CLS_ISTORE;
      OP_IMUL:                    cls_d = CLS_IMUL;
      OP_IINC:                    cls_d = CLS_IINC;
      OP_IFNE:                    cls_d = CLS_IFNE;
      OP_IF_ICMPGT:               cls_d = CLS_ICMPGT;
      OP_GOTO:                    cls_d = CLS_GOTO;
      OP_IRETURN:                 cls_d = CLS_IRETURN;
      OP_RETURN:                  cls_d = CLS_RETURN;
      default:                    cls_d = CLS_UNHANDLED;
    endcase
  end

  // Stack pointer moves and faults depend only on the opcode, the pointer and, for iinc, the local index, so they
  // resolve here and the next word sees the updated pointer at once.
  always_comb begin
    status_d    = ST_CONTINUE;
    sp_d        = sp_q;
    stk_we_d    = 1'b0;
    loc_we_d    = 1'b0;
    stk_waddr_d = STK_AW'(sp_q);
    loc_ridx_d  = LOC_AW'(iload_raw[1:0]);
    loc_widx_d  = LOC_AW'(istore_raw[1:0]);
    unique case (cls_d)
      CLS_ICONST, CLS_ILOAD: begin
        if (can_push) begin
          sp_d     = sp_q + SP_W'(1);
          stk_we_d = 1'b1;
        end else begin
          status_d = ST_STACK_FAULT;
        end
      end
      CLS_ISTORE: begin
        if (can_pop1) begin
          sp_d     = sp_q - SP_W'(1);
          loc_we_d = 1'b1;
        end else begin
          status_d = ST_STACK_FAULT;
        end
      end
      CLS_IMUL: begin
        stk_waddr_d = rd_b_d;
        if (can_pop2) begin
          sp_d     = sp_q - SP_W'(1);
          stk_we_d = 1'b1;
        end else begin
          status_d = ST_STACK_FAULT;
        end
      end
      CLS_IINC: begin
        loc_ridx_d = operand_hi_i[LOC_AW-1:0];
        loc_widx_d = operand_hi_i[LOC_AW-1:0];
        if (9'(operand_hi_i) < 9'(LOCAL_COUNT)) begin
          loc_we_d = 1'b1;
        end else begin
          status_d = ST_LOCAL_FAULT;
        end
      end
      CLS_IFNE: begin
        if (can_pop1) begin
          sp_d = sp_q - SP_W'(1);
        end else begin
          status_d = ST_STACK_FAULT;
        end
      end
      CLS_ICMPGT: begin
        if (can_pop2) begin
          sp_d = sp_q - SP_W'(2);
        end else begin
          status_d = ST_STACK_FAULT;
        end
      end
      CLS_IRETURN: begin
        if (can_pop1) begin
          sp_d     = '0;
          status_d = ST_INT_RETURN;
        end else begin
          status_d = ST_STACK_FAULT;
        end
      end
      CLS_RETURN: begin
        sp_d     = '0;
        status_d = ST_VOID_RETURN;
      end
      CLS_UNHANDLED: begin
        status_d = ST_UNHANDLED;
      end
      default: begin
        status_d = ST_CONTINUE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q          <= '0;
      s1_valid_q    <= 1'b0;
      byp_stk_we_q  <= 1'b0;
      byp_loc_we_q  <= 1'b0;
      loc_written_q <= '0;
    end else begin
      s1_valid_q   <= accept;
      byp_stk_we_q <= stk_we;
      byp_loc_we_q <= loc_we;
      if (accept) begin
        sp_q <= sp_d;
      end
      if (loc_we) begin
        loc_written_q[s1_loc_widx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cls_q       <= cls_d;
      s1_status_q    <= status_d;
      s1_stk_we_q    <= stk_we_d;
      s1_loc_we_q    <= loc_we_d;
      s1_stk_waddr_q <= stk_waddr_d;
      s1_rd_a_q      <= rd_a_d;
      s1_rd_b_q      <= rd_b_d;
      s1_loc_ridx_q  <= loc_ridx_d;
      s1_loc_widx_q  <= loc_widx_d;
      s1_branch_q    <= {operand_hi_i, operand_lo_i};
      s1_lo_q        <= operand_lo_i;
      s1_const_q     <= iconst_raw[3:0];
    end
    byp_stk_addr_q <= s1_stk_waddr_q;
    byp_stk_data_q <= stk_wdata;
    byp_loc_addr_q <= s1_loc_widx_q;
    byp_loc_data_q <= loc_wdata;
  end

  // Stack memory: two read ports, one write port.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[s1_stk_waddr_q] <= stk_wdata;
    end
    stk_rd_a_q <= stk_mem[rd_a_d];
    stk_rd_b_q <= stk_mem[rd_b_d];
  end

  // Local file: one read port, one write port; unwritten entries read as zero.
  always_ff @(posedge clk_i) begin
    if (loc_we) begin
      loc_mem[s1_loc_widx_q] <= loc_wdata;
    end
    loc_rd_q         <= loc_mem[loc_ridx_d];
    loc_rd_written_q <= loc_written_q[loc_ridx_d];
  end

  // A read issued in the same cycle as the previous word's write sees old data, so
  // the write of the last cycle is forwarded.
  always_comb begin
    tos = stk_rd_a_q;
    if (byp_stk_we_q && (byp_stk_addr_q == s1_rd_a_q)) begin
      tos = byp_stk_data_q;
    end
    nos = stk_rd_b_q;
    if (byp_stk_we_q && (byp_stk_addr_q == s1_rd_b_q)) begin
      nos = byp_stk_data_q;
    end
    loc_val = loc_rd_written_q ? loc_rd_q : '0;
    if (byp_loc_we_q && (byp_loc_addr_q == s1_loc_ridx_q)) begin
      loc_val = byp_loc_data_q;
    end
  end

  assign mul_res = nos * tos;
  assign stk_we  = s1_valid_q && s1_stk_we_q;
  assign loc_we  = s1_valid_q && s1_loc_we_q;

  always_comb begin
    case (s1_cls_q)
      CLS_ICONST: stk_wdata = {{(WORD_W - 4){s1_const_q[3]}}, s1_const_q};
      CLS_IMUL:   stk_wdata = mul_res;
      default:    stk_wdata = loc_val;
    endcase
    if (s1_cls_q == CLS_IINC) begin
      loc_wdata = loc_val + {{(WORD_W - 8){s1_lo_q[7]}}, s1_lo_q};
    end else begin
      loc_wdata = tos;
    end
  end

  always_comb begin
    taken = 1'b0;
    case (s1_cls_q)
      CLS_GOTO:   taken = 1'b1;
      CLS_IFNE:   taken = (s1_status_q == ST_CONTINUE) && (tos != '0);
      CLS_ICMPGT: taken = (s1_status_q == ST_CONTINUE) && ($signed(nos) > $signed(tos));
      default:    taken = 1'b0;
    endcase
    res.status = s1_status_q;
    if (taken) begin
      res.pc_offset = s1_branch_q;
    end else if ((s1_cls_q == CLS_IINC) || (s1_cls_q == CLS_IFNE) ||
                 (s1_cls_q == CLS_ICMPGT)) begin
      res.pc_offset = 16'd3;
    end else begin
      res.pc_offset = 16'd1;
    end
    res.return_value = (s1_status_q == ST_INT_RETURN) ? tos : '0;
  end

  sbe_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (res),
    .pop_valid_o (out_valid_o),
    .pop_ready_i (out_ready_i),
    .pop_data_o  (fifo_out),
    .count_o     (fifo_count)
  );

  assign pc_offset_o    = fifo_out.pc_offset;
  assign status_o       = fifo_out.status;
  assign return_value_o = fifo_out.return_value;

  `SBE_ASSERT_NOW(a_sp_in_range, 1'b1, sp_q <= SP_W'(STACK_DEPTH))
  `SBE_ASSERT_NOW(a_no_overrun, 1'b1, occupancy <= (FIFO_CW + 1)'(FIFO_DEPTH))
  `SBE_ASSERT_NEXT(a_accept_reaches_exec, accept, s1_valid_q)
  `SBE_ASSERT_NOW(a_no_write_on_fault, s1_valid_q && (s1_status_q != ST_CONTINUE), !stk_we && !loc_we)

endmodule
